// File: src/tcn_pkg.sv
package tcn_pkg;

    // default field widths
    localparam int TCN_COORD_BITS = 16;
    localparam int TCN_FRAC_BITS  = 16;

    // quotient bits resolved in each divider stage
    localparam int TCN_DIV_STEPS = 2;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_OFFSET = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_OFFSET = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_TURN     = 3'd6;

    // rotation codes
    typedef logic [1:0] t_turn;
    localparam t_turn TURN_NONE = 2'd0;
    localparam t_turn TURN_90   = 2'd1;
    localparam t_turn TURN_180  = 2'd2;
    localparam t_turn TURN_270  = 2'd3;

endpackage

// File: src/tcn_axis.sv
module tcn_axis
    import tcn_pkg::*;
#(
    parameter int COORD_BITS = TCN_COORD_BITS,
    parameter int FRAC_BITS  = TCN_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic [COORD_BITS-1:0] i_raw,
    input  logic [COORD_BITS-1:0] i_min,
    input  logic [COORD_BITS-1:0] i_max,
    input  logic [COORD_BITS:0]   i_offset,
    output logic [FRAC_BITS:0]    o_norm
);

    localparam int DIV_STAGES = (FRAC_BITS + TCN_DIV_STEPS - 1) / TCN_DIV_STEPS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // stage a: active minimum, offset added and clamped into min .. max
    logic signed [COORD_BITS+1:0] w_sum;
    logic [COORD_BITS:0]          w_act_wide;
    logic [COORD_BITS-1:0]        w_act;

    assign w_sum = signed'({2'b00, i_min}) + signed'({i_offset[COORD_BITS], i_offset});
    assign w_act_wide = i_offset[COORD_BITS] ? {1'b0, i_min} : w_sum[COORD_BITS:0];
    assign w_act = (w_act_wide > {1'b0, i_max}) ? i_max : w_act_wide[COORD_BITS-1:0];

    logic [COORD_BITS-1:0] r_a_raw;
    logic [COORD_BITS-1:0] r_a_act;
    logic [COORD_BITS-1:0] r_a_max;

    always_ff @(posedge i_clk) begin
        r_a_raw <= i_raw;
        r_a_act <= w_act;
        r_a_max <= i_max;
    end

    // stage b: span, distance above minimum, empty and saturate flags
    logic [COORD_BITS-1:0] w_span;
    logic [COORD_BITS-1:0] w_diff;
    logic                  w_zero;
    logic                  w_sat;

    assign w_span = r_a_max - r_a_act;
    assign w_diff = r_a_raw - r_a_act;
    assign w_zero = (r_a_max <= r_a_act) || (r_a_raw <= r_a_act);
    assign w_sat  = !w_zero && (w_diff >= w_span);

    logic [COORD_BITS-1:0] r_rem  [0:DIV_STAGES];
    logic [COORD_BITS-1:0] r_span [0:DIV_STAGES];
    logic [FRAC_BITS-1:0]  r_quo  [0:DIV_STAGES];
    logic                  r_zero [0:DIV_STAGES];
    logic                  r_sat  [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= w_sat ? '0 : w_diff;
        r_span[0] <= w_span;
        r_quo[0]  <= '0;
        r_zero[0] <= w_zero;
        r_sat[0]  <= w_sat;
    end

    // restoring divider, TCN_DIV_STEPS quotient bits per stage; outside the empty case the remainder stays below span
    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
        logic [COORD_BITS-1:0] n_rem;
        logic [FRAC_BITS-1:0]  n_quo;

        always_comb begin
            logic [COORD_BITS:0] v_t;
            logic                v_bit;
            n_rem = r_rem[s-1];
            n_quo = r_quo[s-1];
            v_t   = '0;
            v_bit = 1'b0;
            for (int k = 0; k < TCN_DIV_STEPS; k++) begin
                if ((s - 1) * TCN_DIV_STEPS + k < FRAC_BITS) begin
                    v_t   = {n_rem, 1'b0};
                    v_bit = (v_t >= {1'b0, r_span[s-1]});
                    if (v_bit) begin
                        v_t = v_t - {1'b0, r_span[s-1]};
                    end
                    n_rem = v_t[COORD_BITS-1:0];
                    n_quo = {n_quo[FRAC_BITS-2:0], v_bit};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_span[s] <= r_span[s-1];
            r_quo[s]  <= n_quo;
            r_zero[s] <= r_zero[s-1];
            r_sat[s]  <= r_sat[s-1];
        end
    end

    // final select: empty or below range gives zero, at or past max gives one
    always_comb begin
        if (r_zero[DIV_STAGES]) begin
            o_norm = '0;
        end else if (r_sat[DIV_STAGES]) begin
            o_norm = ONE;
        end else begin
            o_norm = {1'b0, r_quo[DIV_STAGES]};
        end
    end

endmodule

// File: src/touch_coordinate_normalizer_top.sv
// channel   direction  handshake                 payload
// sample    in         i_start (o_busy held low)  i_raw_x, i_raw_y
// result    out        o_valid strobe             o_norm_x, o_norm_y
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one sample may start in every cycle; its result strobes once it has passed the stage a and
// stage b registers, the two-bit-per-stage divider pipeline of each axis and the output register
// reset is synchronous, active low, and clears the valid chain and the configuration registers
// the receiver cannot stall, so nothing holds the pipeline and o_busy stays low
module touch_coordinate_normalizer_top
    import tcn_pkg::*;
#(
    parameter int COORD_BITS = TCN_COORD_BITS,
    parameter int FRAC_BITS  = TCN_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [COORD_BITS-1:0]   i_raw_x,
    input  logic [COORD_BITS-1:0]   i_raw_y,
    output logic                    o_valid,
    output logic [FRAC_BITS:0]      o_norm_x,
    output logic [FRAC_BITS:0]      o_norm_y,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS:0]     i_cfg_data
);

    localparam int DIV_STAGES = (FRAC_BITS + TCN_DIV_STEPS - 1) / TCN_DIV_STEPS;
    localparam int LATENCY    = DIV_STAGES + 3;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // configuration registers
    logic [COORD_BITS-1:0] r_x_min;
    logic [COORD_BITS-1:0] r_x_max;
    logic [COORD_BITS-1:0] r_y_min;
    logic [COORD_BITS-1:0] r_y_max;
    logic [COORD_BITS:0]   r_x_offset;
    logic [COORD_BITS:0]   r_y_offset;
    t_turn                 r_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min    <= '0;
            r_x_max    <= '1;
            r_y_min    <= '0;
            r_y_max    <= '1;
            r_x_offset <= '0;
            r_y_offset <= '0;
            r_turn     <= TURN_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_MIN:    r_x_min    <= i_cfg_data[COORD_BITS-1:0];
                REG_X_MAX:    r_x_max    <= i_cfg_data[COORD_BITS-1:0];
                REG_Y_MIN:    r_y_min    <= i_cfg_data[COORD_BITS-1:0];
                REG_Y_MAX:    r_y_max    <= i_cfg_data[COORD_BITS-1:0];
                REG_X_OFFSET: r_x_offset <= i_cfg_data;
                REG_Y_OFFSET: r_y_offset <= i_cfg_data;
                REG_TURN:     r_turn     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // fully pipelined, never busy
    assign o_busy = 1'b0;

    // valid bits travel beside the axis pipelines
    logic [LATENCY-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], i_start};
        end
    end

    // per-axis normalize and divide
    logic [FRAC_BITS:0] w_nx;
    logic [FRAC_BITS:0] w_ny;

    tcn_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_raw    (i_raw_x),
        .i_min    (r_x_min),
        .i_max    (r_x_max),
        .i_offset (r_x_offset),
        .o_norm   (w_nx)
    );

    tcn_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_raw    (i_raw_y),
        .i_min    (r_y_min),
        .i_max    (r_y_max),
        .i_offset (r_y_offset),
        .o_norm   (w_ny)
    );

    // rotation into the output word
    logic [FRAC_BITS:0] n_out_x;
    logic [FRAC_BITS:0] n_out_y;
    logic [FRAC_BITS:0] r_out_x;
    logic [FRAC_BITS:0] r_out_y;

    always_comb begin
        unique case (r_turn)
            TURN_90: begin
                n_out_x = w_ny;
                n_out_y = ONE - w_nx;
            end
            TURN_180: begin
                n_out_x = ONE - w_nx;
                n_out_y = ONE - w_ny;
            end
            TURN_270: begin
                n_out_x = ONE - w_ny;
                n_out_y = w_nx;
            end
            default: begin
                n_out_x = w_nx;
                n_out_y = w_ny;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    assign o_valid  = r_vld[LATENCY-1];
    assign o_norm_x = r_out_x;
    assign o_norm_y = r_out_y;

endmodule

// File: src/tcn_checker.sv
module tcn_checker #(
    parameter int FRAC_BITS = 16,
    parameter int LATENCY   = 11
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input logic [FRAC_BITS:0] o_norm_x,
    input logic [FRAC_BITS:0] o_norm_y
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // every accepted sample gives a word after the pipeline latency
    a_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_valid)
        else $error("accepted sample produced no word");

    // no word appears without a sample behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("word without an accepted sample");

    // positions stay within the unit interval
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm_x <= ONE) && (o_norm_y <= ONE))
        else $error("position beyond one");

endmodule

bind touch_coordinate_normalizer_top tcn_checker #(
    .FRAC_BITS (FRAC_BITS),
    .LATENCY   (LATENCY)
) u_tcn_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_norm_x (o_norm_x),
    .o_norm_y (o_norm_y)
);

// File: sim/testbench.sv
`default_nettype none

module testbench;
    import tcn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = TCN_COORD_BITS;
    localparam int FRAC_BITS  = TCN_FRAC_BITS;
    localparam int LATENCY    = (FRAC_BITS + 1) / 2 + 3;
    localparam int DRAIN_LIMIT = 50 * LATENCY;
    localparam logic [FRAC_BITS:0] UNIT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_TOP = '1;

    // an index past the register file, writes to it must be dropped
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    localparam int RANDOM_PHASES    = 20;
    localparam int WORDS_PER_PHASE  = 46;
    localparam int STEADY_PHASE     = 9;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_offset;
    typedef logic [FRAC_BITS:0]    t_frac;

    typedef struct packed {
        t_frac x;
        t_frac y;
    } t_position;

    typedef struct {
        t_coord  x_min;
        t_coord  x_max;
        t_coord  y_min;
        t_coord  y_max;
        t_offset x_off;
        t_offset y_off;
        t_turn   turn;
    } t_axis_regs;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    t_coord                  i_raw_x;
    t_coord                  i_raw_y;
    logic                    o_valid;
    t_frac                   o_norm_x;
    t_frac                   o_norm_y;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    t_offset                 i_cfg_data;

    t_position  pending_positions[$];
    t_axis_regs cur_regs;
    logic       steady_feed;
    int         error_count;
    int         samples_sent;
    int         positions_seen;
    int         reg_writes;
    int         settings_used;

    touch_coordinate_normalizer_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .o_busy    (o_busy),
        .i_raw_x   (i_raw_x),
        .i_raw_y   (i_raw_y),
        .o_valid   (o_valid),
        .o_norm_x  (o_norm_x),
        .o_norm_y  (o_norm_y),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // one axis: clamp the shifted minimum, then truncating divide into Q1.FRAC_BITS
    function automatic t_frac scale_axis(t_coord raw, t_coord lo, t_coord hi, t_offset off);
        longint value;
        longint mn;
        longint mx;
        longint act;
        longint q;
        value = raw;
        mn = lo;
        mx = hi;
        act = mn + $signed(off);
        if (act < mn) act = mn;
        if (act > mx) act = mx;
        if (mx <= act || value <= act) return '0;
        q = ((value - act) << FRAC_BITS) / (mx - act);
        if (q > longint'(UNIT_ONE)) q = UNIT_ONE;
        return t_frac'(q);
    endfunction

    // normalized pair after the rotation in the turn register
    function automatic t_position predict_position(t_coord rx, t_coord ry);
        t_frac nx;
        t_frac ny;
        t_position p;
        nx = scale_axis(rx, cur_regs.x_min, cur_regs.x_max, cur_regs.x_off);
        ny = scale_axis(ry, cur_regs.y_min, cur_regs.y_max, cur_regs.y_off);
        case (cur_regs.turn)
            TURN_90: begin
                p.x = ny;
                p.y = UNIT_ONE - nx;
            end
            TURN_180: begin
                p.x = UNIT_ONE - nx;
                p.y = UNIT_ONE - ny;
            end
            TURN_270: begin
                p.x = UNIT_ONE - ny;
                p.y = nx;
            end
            default: begin
                p.x = nx;
                p.y = ny;
            end
        endcase
        return p;
    endfunction

    // register write, mirrored with the same masking the block applies
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input t_offset data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            REG_X_MIN:    cur_regs.x_min = data[COORD_BITS-1:0];
            REG_X_MAX:    cur_regs.x_max = data[COORD_BITS-1:0];
            REG_Y_MIN:    cur_regs.y_min = data[COORD_BITS-1:0];
            REG_Y_MAX:    cur_regs.y_max = data[COORD_BITS-1:0];
            REG_X_OFFSET: cur_regs.x_off = data;
            REG_Y_OFFSET: cur_regs.y_off = data;
            REG_TURN:     cur_regs.turn  = t_turn'(data[1:0]);
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // send one sample word, with random idle cycles ahead of it unless the feed is steady
    task automatic send_sample(input t_coord rx, input t_coord ry);
        while (!steady_feed && $urandom_range(99) < 25) begin
            @(negedge i_clk);
            i_start = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_start = 1'b1;
        i_raw_x = rx;
        i_raw_y = ry;
        do @(posedge i_clk); while (o_busy);
        pending_positions.push_back(predict_position(rx, ry));
        samples_sent++;
    endtask

    // stop feeding and let every word in flight come out
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_positions.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_positions.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      pending_positions.size()));
            pending_positions.delete();
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // result checker, oldest prediction first
    always @(posedge i_clk) begin
        t_position want;
        if (i_rst_n && o_valid) begin
            positions_seen++;
            if (pending_positions.size() == 0) begin
                report_mismatch($sformatf("unexpected result word x=%0d y=%0d",
                                          o_norm_x, o_norm_y));
            end else begin
                want = pending_positions.pop_front();
                if (o_norm_x !== want.x)
                    report_mismatch($sformatf("norm_x got %0d want %0d", o_norm_x, want.x));
                if (o_norm_y !== want.y)
                    report_mismatch($sformatf("norm_y got %0d want %0d", o_norm_y, want.y));
            end
        end
    end

    // full window, every rotation off
    task automatic test_default_range();
        wait_drained();
        send_sample(16'd0, 16'd0);
        send_sample(COORD_TOP, COORD_TOP);
        send_sample(16'd1, 16'd65534);
        send_sample(16'd32768, 16'd16384);
    endtask

    // every rotation code over the full window
    task automatic test_rotations();
        t_turn turns[4];
        turns = '{TURN_NONE, TURN_90, TURN_180, TURN_270};
        foreach (turns[i]) begin
            wait_drained();
            write_register(REG_TURN, t_offset'(turns[i]));
            settings_used++;
            send_sample(16'd0, COORD_TOP);
            send_sample(16'd16384, 16'd49152);
        end
        wait_drained();
        write_register(REG_TURN, t_offset'(TURN_NONE));
    endtask

    // clamping, empty spans, offset extremes, masking of wide data
    task automatic test_axis_corners();
        // below the minimum, above the maximum, span of one
        wait_drained();
        write_register(REG_X_MIN, 17'd1000);
        write_register(REG_X_MAX, 17'd2000);
        write_register(REG_Y_MIN, 17'd3000);
        write_register(REG_Y_MAX, 17'd3001);
        settings_used++;
        send_sample(16'd999, 16'd3000);
        send_sample(16'd2500, 16'd3002);
        send_sample(16'd1500, 16'd3001);

        // minimum above maximum, and minimum equal to maximum
        wait_drained();
        write_register(REG_X_MIN, 17'd2000);
        write_register(REG_X_MAX, 17'd1000);
        write_register(REG_Y_MIN, 17'd500);
        write_register(REG_Y_MAX, 17'd500);
        settings_used++;
        send_sample(16'd1500, 16'd500);

        // offset lands exactly on the maximum, most negative offset
        wait_drained();
        write_register(REG_X_MIN, 17'd1000);
        write_register(REG_X_MAX, 17'd2000);
        write_register(REG_X_OFFSET, 17'd1000);
        write_register(REG_Y_MIN, 17'd0);
        write_register(REG_Y_MAX, 17'(COORD_TOP));
        write_register(REG_Y_OFFSET, 17'h10000);
        settings_used++;
        send_sample(16'd1999, 16'd1);
        send_sample(16'd2000, COORD_TOP);

        // largest positive offset clamps to max, minus one clamps to min
        wait_drained();
        write_register(REG_X_OFFSET, 17'h0FFFF);
        write_register(REG_Y_OFFSET, 17'h1FFFF);
        settings_used++;
        send_sample(16'd1500, 16'd12345);

        // bits above the field width dropped, and a write past the last index
        wait_drained();
        write_register(REG_X_OFFSET, 17'd0);
        write_register(REG_X_MAX, 17'h10FFF);
        write_register(REG_TURN, 17'h1FFFE);
        write_register(REG_UNUSED, 17'h1ABCD);
        settings_used++;
        send_sample(16'd2047, 16'd40000);
        send_sample(16'h8000, 16'h7FFF);
    endtask

    function automatic t_coord pick_bound();
        case ($urandom_range(9))
            0: return '0;
            1: return COORD_TOP;
            2: return t_coord'($urandom_range(15));
            3: return COORD_TOP - t_coord'($urandom_range(15));
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_offset pick_offset(t_coord lo, t_coord hi);
        int span;
        span = int'(hi) - int'(lo);
        case ($urandom_range(9))
            0: return 17'h10000;
            1: return 17'h0FFFF;
            2: return t_offset'($urandom);
            3: return '0;
            4: return t_offset'(-int'($urandom_range(300)));
            default: begin
                if (span > 0)
                    return t_offset'(int'($urandom_range(span)) - span / 8);
                return t_offset'(int'($urandom_range(64)) - 32);
            end
        endcase
    endfunction

    // samples bunch around the window edges and the shifted minimum
    function automatic t_coord pick_sample(t_coord lo, t_coord hi, t_offset off);
        int base;
        case ($urandom_range(7))
            3: base = lo;
            4: base = hi;
            5: base = int'(lo) + $signed(off);
            6: return $urandom_range(1) ? COORD_TOP : t_coord'(0);
            default: return t_coord'($urandom);
        endcase
        return t_coord'(base + int'($urandom_range(8)) - 4);
    endfunction

    // new random window per axis; unused upper data bits carry noise
    task automatic randomize_registers();
        t_coord lo;
        t_coord hi;
        t_coord tmp;
        lo = pick_bound();
        hi = pick_bound();
        if (lo > hi && $urandom_range(99) < 75) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        write_register(REG_X_MIN, {1'($urandom), lo});
        write_register(REG_X_MAX, {1'($urandom), hi});
        write_register(REG_X_OFFSET, pick_offset(lo, hi));
        lo = pick_bound();
        hi = pick_bound();
        if (lo > hi && $urandom_range(99) < 75) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        write_register(REG_Y_MIN, {1'($urandom), lo});
        write_register(REG_Y_MAX, {1'($urandom), hi});
        write_register(REG_Y_OFFSET, pick_offset(lo, hi));
        write_register(REG_TURN, {15'($urandom), 2'($urandom_range(3))});
        if ($urandom_range(3) == 0)
            write_register(REG_UNUSED, t_offset'($urandom));
        settings_used++;
    endtask

    // random windows, each followed by a burst of sample words
    task automatic test_random_windows();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            randomize_registers();
            steady_feed = (phase == STEADY_PHASE);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_sample(pick_sample(cur_regs.x_min, cur_regs.x_max, cur_regs.x_off),
                            pick_sample(cur_regs.y_min, cur_regs.y_max, cur_regs.y_off));
            end
        end
        steady_feed = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_raw_x        = '0;
        i_raw_y        = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_X_MIN;
        i_cfg_data     = '0;
        steady_feed    = 1'b0;
        error_count    = 0;
        samples_sent   = 0;
        positions_seen = 0;
        reg_writes     = 0;
        settings_used  = 1;
        cur_regs.x_min = '0;
        cur_regs.x_max = COORD_TOP;
        cur_regs.y_min = '0;
        cur_regs.y_max = COORD_TOP;
        cur_regs.x_off = '0;
        cur_regs.y_off = '0;
        cur_regs.turn  = TURN_NONE;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_range();
        test_rotations();
        test_axis_corners();
        test_random_windows();
        wait_drained();

        $display("run covered %0d sample words under %0d register settings (%0d writes)",
                 samples_sent, settings_used, reg_writes);
        $display("%0d result words checked, %0d mismatches", positions_seen, error_count);
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #2_000_000;
        $display("timeout with %0d result words outstanding", pending_positions.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
